FILE: rtl/core/dwg_pkg.sv
// Shared types, constants and the sine table function for the dual wave DAC generator.
// Used by dwg_wave_calc and dual_wave_dac_generator; depends on nothing else.
`default_nettype none

package dwg_pkg;

  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 8;
  localparam int SINE_ENTRIES    = 1 << SINE_TABLE_BITS;
  localparam int SINE_QUARTER    = 1 << (SINE_TABLE_BITS - 2);

  localparam int STEP_W   = 32;
  localparam int CODE_W   = 10;
  localparam int WORD_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SINE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRI_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CODE = 2'd3;

  localparam logic [STEP_W-1:0] SINE_STEP_RESET = 32'd8589935;
  localparam logic [STEP_W-1:0] TRI_STEP_RESET  = 32'd4294967;
  localparam logic [CODE_W-1:0] LOW_CODE_RESET  = 10'd47;
  localparam logic [CODE_W-1:0] HIGH_CODE_RESET = 10'd899;

  // DAC command word control bits.
  localparam logic CHAN_A_BIT = 1'b0;
  localparam logic CHAN_B_BIT = 1'b1;
  localparam logic GAIN_1X    = 1'b1;
  localparam logic ACTIVE     = 1'b1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [STEP_W-1:0] sine_step;
    logic [STEP_W-1:0] tri_step;
    logic [CODE_W-1:0] low_code;
    logic [CODE_W-1:0] high_code;
  } dwg_cfg_t;

  // Quarter-wave sine in Q1.15 by a Taylor series in Q2.30; m runs 0..SINE_QUARTER.
  function automatic logic [15:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] acc;
    logic [63:0] r;
    x   = (m * HALF_PI_Q30) / SINE_QUARTER;
    x2  = (x * x) >> 30;
    t   = x;
    acc = $signed(x);
    t = ((t * x2) >> 30) / 6;   acc = acc - $signed(t);
    t = ((t * x2) >> 30) / 20;  acc = acc + $signed(t);
    t = ((t * x2) >> 30) / 42;  acc = acc - $signed(t);
    t = ((t * x2) >> 30) / 72;  acc = acc + $signed(t);
    t = ((t * x2) >> 30) / 110; acc = acc - $signed(t);
    t = ((t * x2) >> 30) / 156; acc = acc + $signed(t);
    t = ((t * x2) >> 30) / 210; acc = acc - $signed(t);
    if (acc < 0) begin
      acc = 0;
    end
    r = ($unsigned(acc) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[15:0];
  endfunction

  // Full-wave table entry built from the quarter wave by symmetry.
  function automatic logic signed [15:0] sine_entry(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0] quad;
    logic [63:0] k;
    logic [15:0] v;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    k    = 64'(idx[SINE_TABLE_BITS-3:0]);
    v    = quad[0] ? quarter_sine(64'(SINE_QUARTER) - k) : quarter_sine(k);
    return quad[1] ? -$signed(v) : $signed(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dwg_wave_calc.sv
// Sample datapath: sine table lookup and scaling, triangle scaling, saturation.
// Purely combinational; depends on dwg_pkg.
`default_nettype none

module dwg_wave_calc (
  input  wire dwg_pkg::dwg_cfg_t                 cfg,
  input  wire logic [dwg_pkg::PHASE_BITS-1:0]    sine_phase,
  input  wire logic [dwg_pkg::PHASE_BITS-1:0]    tri_phase,
  output logic      [dwg_pkg::CODE_W-1:0]        code_a,
  output logic      [dwg_pkg::CODE_W-1:0]        code_b
);

  localparam int P  = dwg_pkg::PHASE_BITS;
  localparam int TB = dwg_pkg::SINE_TABLE_BITS;

  localparam logic [P+12:0] TRI_HALF = (P+13)'(1) << (P - 1);

  logic signed [15:0] sine_rom [dwg_pkg::SINE_ENTRIES];

  for (genvar i = 0; i < dwg_pkg::SINE_ENTRIES; i++) begin : g_rom
    assign sine_rom[i] = dwg_pkg::sine_entry(TB'(i));
  end

  logic [P-1:0]        sine_addr;
  logic [TB-1:0]       sine_idx;
  logic signed [15:0]  sine_val;
  logic signed [10:0]  diff;
  logic [10:0]         sum_lh;
  logic signed [28:0]  sine_prod;
  logic signed [28:0]  sine_num;
  logic [P:0]          tri_dbl;
  logic [P:0]          tri_u;
  logic signed [P+12:0] tri_prod;
  logic signed [P+12:0] tri_num;

  // The table is sampled half a step ahead of the phase to centre each sample.
  assign sine_addr = sine_phase + (P'(cfg.sine_step) >> 1);
  assign sine_idx  = sine_addr[P-1 -: TB];
  assign sine_val  = sine_rom[sine_idx];

  assign diff   = $signed({1'b0, cfg.high_code}) - $signed({1'b0, cfg.low_code});
  assign sum_lh = {1'b0, cfg.low_code} + {1'b0, cfg.high_code};

  assign sine_prod = 29'(diff) * 29'(sine_val);
  assign sine_num  = $signed({3'b000, sum_lh, 15'b0}) + sine_prod + 29'sd32768;

  always_comb begin
    if (sine_num[28]) begin
      code_a = '0;
    end else if (sine_num[27:26] != 2'b00) begin
      code_a = '1;
    end else begin
      code_a = sine_num[25:16];
    end
  end

  // The triangle rises over the first half turn and falls over the second.
  assign tri_dbl = {tri_phase, 1'b0};
  assign tri_u   = tri_phase[P-1] ? ((P+1)'(0) - tri_dbl) : tri_dbl;

  assign tri_prod = (P+13)'($signed({1'b0, tri_u})) * (P+13)'(diff);
  assign tri_num  = $signed({3'b000, cfg.low_code, {P{1'b0}}}) + tri_prod + $signed(TRI_HALF);

  always_comb begin
    if (tri_num[P+12]) begin
      code_b = '0;
    end else if (tri_num[P+11:P+10] != 2'b00) begin
      code_b = '1;
    end else begin
      code_b = tri_num[P+9:P];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/dual_wave_dac_generator.sv
// Top level of the dual wave DAC generator: configuration registers, phase
// accumulators and the result register. Depends on dwg_pkg and dwg_wave_calc.
//
// Usage:
//   The input channel (in_valid, in_ready, tick) carries one transaction per
//   sample request. A transaction with tick high takes a sample of both waves
//   from the current phases and then advances both accumulators by their
//   steps; one with tick low is consumed and changes nothing.
//   The output channel (out_valid, out_ready, word_a, word_b, code_a, code_b)
//   presents the sample in the cycle after its tick was accepted, held in the
//   result register until it is taken.
//   Throughput is one transaction per cycle while samples are taken: the phase
//   add, the table read and the one multiply per wave all sit between the phase
//   registers and the result register. in_ready is high whenever the result
//   register is empty or is being emptied in the same cycle, so a stalled
//   receiver holds off the input only while its sample is still waiting.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at the
//   next clock edge and should be made while no sample is outstanding.
//   Synchronous reset clears both phases and out_valid, and loads
//   the default steps and code range.
`default_nettype none

module dual_wave_dac_generator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [dwg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dwg_pkg::STEP_W-1:0]         cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               tick,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [dwg_pkg::WORD_W-1:0]         word_a,
  output logic      [dwg_pkg::WORD_W-1:0]         word_b,
  output logic      [dwg_pkg::CODE_W-1:0]         code_a,
  output logic      [dwg_pkg::CODE_W-1:0]         code_b
);

  localparam int P = dwg_pkg::PHASE_BITS;

  dwg_pkg::dwg_cfg_t cfg;
  logic [P-1:0] sine_phase;
  logic [P-1:0] tri_phase;
  logic [dwg_pkg::CODE_W-1:0] calc_a;
  logic [dwg_pkg::CODE_W-1:0] calc_b;
  logic take_tick;

  assign in_ready  = !out_valid || out_ready;
  assign take_tick = in_valid && in_ready && tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sine_step <= dwg_pkg::SINE_STEP_RESET;
      cfg.tri_step  <= dwg_pkg::TRI_STEP_RESET;
      cfg.low_code  <= dwg_pkg::LOW_CODE_RESET;
      cfg.high_code <= dwg_pkg::HIGH_CODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dwg_pkg::CFG_SINE_STEP: cfg.sine_step <= cfg_data;
        dwg_pkg::CFG_TRI_STEP:  cfg.tri_step  <= cfg_data;
        dwg_pkg::CFG_LOW_CODE:  cfg.low_code  <= cfg_data[dwg_pkg::CODE_W-1:0];
        dwg_pkg::CFG_HIGH_CODE: cfg.high_code <= cfg_data[dwg_pkg::CODE_W-1:0];
      endcase
    end
  end

  dwg_wave_calc u_calc (
    .cfg        (cfg),
    .sine_phase (sine_phase),
    .tri_phase  (tri_phase),
    .code_a     (calc_a),
    .code_b     (calc_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_phase <= '0;
      tri_phase  <= '0;
    end else if (take_tick) begin
      sine_phase <= sine_phase + P'(cfg.sine_step);
      tri_phase  <= tri_phase + P'(cfg.tri_step);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers need no reset; they are loaded with every sample.
  always_ff @(posedge clk) begin
    if (take_tick) begin
      code_a <= calc_a;
      code_b <= calc_b;
      word_a <= {dwg_pkg::CHAN_A_BIT, 1'b0, dwg_pkg::GAIN_1X, dwg_pkg::ACTIVE, calc_a, 2'b00};
      word_b <= {dwg_pkg::CHAN_B_BIT, 1'b0, dwg_pkg::GAIN_1X, dwg_pkg::ACTIVE, calc_b, 2'b00};
    end
  end

  a_tick_gives_sample: assert property (@(posedge clk) disable iff (rst)
    take_tick |=> out_valid)
    else $error("accepted tick did not produce a sample");

  a_words_match_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_a[11:2] == code_a) && (word_b[11:2] == code_b))
    else $error("command words disagree with sample codes");

  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !rst && !take_tick |=> $stable(sine_phase) && $stable(tri_phase))
    else $error("phase moved without an accepted tick");

  a_phase_steps: assert property (@(posedge clk) disable iff (rst)
    !rst && take_tick |=> sine_phase == P'($past(sine_phase) + P'($past(cfg.sine_step))))
    else $error("sine phase did not advance by its step");

endmodule

`default_nettype wire
